### hw/rtl/b2oc_pkg.sv
// b2oc_pkg: shared types and constants for the binned offset correction unit
// no dependencies
`timescale 1ns / 1ps
package b2oc_pkg;

    localparam int BinsPerAxis = 12;
    localparam int NumBins     = BinsPerAxis * BinsPerAxis;
    localparam int BinW        = $clog2(NumBins);
    localparam int AxW         = $clog2(BinsPerAxis);
    localparam int SumW        = 48;
    localparam int CntW        = 24;
    localparam int OffW        = 32;
    localparam int MemW        = SumW + CntW;
    localparam int QDepth      = 4;
    localparam int QPtrW       = $clog2(QDepth);

    typedef enum logic [1:0] {
        ACT_ACC  = 2'd0,
        ACT_FIN  = 2'd1,
        ACT_LOOK = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_WLOW  = 2'd0,
        REG_WHIGH = 2'd1,
        REG_MINC  = 2'd2
    } t_reg_idx;

    // back part sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ACC_RD, ST_ACC_WR, ST_LK_RD, ST_LK_OUT,
        ST_SUM_RD, ST_SUM_ACC, ST_GDIV, ST_GWAIT, ST_BIN_RD, ST_BIN_CHK,
        ST_BDIV, ST_BWAIT
    } t_bstate;

    // classified command handed from the front to the back
    typedef struct packed {
        t_action                 act;
        logic                    in_win;
        logic [BinW-1:0]         bin;
        logic signed [23:0]      value;
    } t_cmd;

endpackage

### hw/rtl/b2oc_ram.sv
// b2oc_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module b2oc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/b2oc_divider.sv
// b2oc_divider: multi-cycle signed division, one quotient bit per cycle, truncates to zero
// depends on b2oc_pkg
`timescale 1ns / 1ps
module b2oc_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [b2oc_pkg::SumW+8:0] i_num,
    input  logic [b2oc_pkg::CntW+8:0]     i_den,
    output logic                          o_done,
    output logic signed [b2oc_pkg::SumW+8:0] o_quot
);
    import b2oc_pkg::*;
    localparam int NW = SumW + 9;
    localparam int DW = CntW + 9;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic [NW-1:0] mag;

    assign mag   = i_num[NW-1] ? (~i_num + 1'b1) : i_num;
    assign trial = {r_rem[DW-1:0], r_q[NW-1]};

    // restoring division step
    always_comb begin
        n_q   = {r_q[NW-2:0], 1'b0};
        n_rem = trial;
        if (trial >= {1'b0, r_den}) begin
            n_rem = trial - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= mag;
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[NW-1];
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(~r_q + 1'b1) : $signed(r_q);
endmodule

### hw/rtl/b2oc_front.sv
// b2oc_front: accepts items, locates the bin and queues classified commands
// depends on b2oc_pkg
`timescale 1ns / 1ps
module b2oc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [1:0]               i_action,
    input  logic signed [15:0]       i_coord_x,
    input  logic signed [15:0]       i_coord_y,
    input  logic signed [23:0]       i_sample_value,
    input  logic signed [15:0]       i_wlow,
    input  logic signed [15:0]       i_whigh,
    input  logic                     i_cmd_take,
    output logic                     o_cmd_valid,
    output b2oc_pkg::t_cmd           o_cmd
);
    import b2oc_pkg::*;

    // stage one: raw capture
    logic        r_s1_v;
    logic [1:0]  r_s1_act;
    logic signed [16:0] r_dx, r_dy, r_span;
    logic        r_s1_in;
    logic signed [23:0] r_s1_val;
    // stage two: scaled offsets
    logic        r_s2_v;
    t_cmd        r_s2_cmd;
    logic [20:0] r_px, r_py;
    logic [16:0] r_s2_span;
    // queue
    t_cmd            r_q [QDepth];
    logic [QPtrW-1:0] r_wp, r_rp;
    logic [QPtrW:0]   r_cnt;
    logic            s2_load, q_push, q_pop, accept;
    logic signed [16:0] x17, y17, lo17, hi17;
    logic [AxW-1:0]  ix, iy;
    t_cmd            s2_out;

    assign x17  = 17'(i_coord_x);
    assign y17  = 17'(i_coord_y);
    assign lo17 = 17'(i_wlow);
    assign hi17 = 17'(i_whigh);

    // reserve room for both pipeline stages in the queue
    assign o_full = (32'(r_cnt) + 32'(r_s1_v) + 32'(r_s2_v)) >= QDepth;
    assign accept = i_push && !o_full;

    // stage one: window test and offsets from the low edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
        r_s1_act <= i_action;
        r_dx     <= x17 - lo17;
        r_dy     <= y17 - lo17;
        r_span   <= hi17 - lo17;
        r_s1_in  <= (x17 >= lo17) && (x17 < hi17) && (y17 >= lo17) && (y17 < hi17);
        r_s1_val <= i_sample_value;
    end

    // stage two: scale by bins per axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        r_s2_cmd.act    <= t_action'(r_s1_act);
        r_s2_cmd.in_win <= r_s1_in;
        r_s2_cmd.value  <= r_s1_val;
        r_s2_cmd.bin    <= '0;
        r_px      <= 21'(r_dx[15:0]) * 21'(BinsPerAxis);
        r_py      <= 21'(r_dy[15:0]) * 21'(BinsPerAxis);
        r_s2_span <= r_span;
    end

    // bin search: quotient is below bins per axis, find by compare
    always_comb begin
        ix = '0;
        iy = '0;
        for (int k = 1; k < BinsPerAxis; k++) begin
            if (r_px >= 21'(k) * 21'(r_s2_span[15:0])) ix = AxW'(k);
            if (r_py >= 21'(k) * 21'(r_s2_span[15:0])) iy = AxW'(k);
        end
        s2_out     = r_s2_cmd;
        s2_out.bin = BinW'(32'(ix) * BinsPerAxis + 32'(iy));
    end

    assign q_push = r_s2_v;
    assign q_pop  = i_cmd_take && (r_cnt != '0);
    assign s2_load = q_push;

    // command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (s2_load) begin
                r_wp <= r_wp + 1'b1;
            end
            if (q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPtrW+1)'(q_push) - (QPtrW+1)'(q_pop);
        end
        if (s2_load) begin
            r_q[r_wp] <= s2_out;
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPtrW+1)'(QDepth)) else $error("command queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> r_cnt != '0) else $error("pop from empty queue");
    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_v) else $error("stage one lost item");
endmodule

### hw/rtl/b2oc_back.sv
// b2oc_back: executes accumulate, finalize and lookup commands on the bin stores
// depends on b2oc_pkg, b2oc_ram, b2oc_divider
`timescale 1ns / 1ps
module b2oc_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  b2oc_pkg::t_cmd           i_cmd,
    output logic                     o_cmd_take,
    input  logic [23:0]              i_min_count,
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic signed [31:0]       o_offset,
    output logic                     o_bin_hit,
    output logic                     o_busy
);
    import b2oc_pkg::*;

    localparam int NW = SumW + 9;
    localparam int DW = CntW + 9;

    t_bstate r_st, n_st;
    logic [BinW-1:0] r_idx, n_idx;
    t_cmd   r_cmd;
    logic   r_ready;
    logic signed [NW-1:0] r_gs;
    logic [DW-1:0] r_gc;
    logic signed [OffW-1:0] r_gm;
    logic   r_ov, n_ov;
    logic signed [OffW-1:0] r_ov_off;
    logic   r_ov_hit;

    logic   sc_we, of_we;
    logic [BinW-1:0] sc_waddr, sc_raddr, of_waddr, of_raddr;
    logic [MemW-1:0] sc_wdata, sc_rdata;
    logic [OffW-1:0] of_wdata, of_rdata;
    logic signed [SumW-1:0] rd_sum;
    logic [CntW-1:0] rd_cnt;
    logic   dv_start, dv_done;
    logic signed [NW-1:0] dv_num, dv_quot;
    logic [DW-1:0] dv_den;
    logic   take;
    logic signed [63:0] bofs;

    assign rd_sum = sc_rdata[MemW-1:CntW];
    assign rd_cnt = sc_rdata[CntW-1:0];

    b2oc_ram #(.WIDTH(MemW), .DEPTH(NumBins)) u_sc (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(sc_waddr), .i_wdata(sc_wdata),
        .i_raddr(sc_raddr), .o_rdata(sc_rdata));
    b2oc_ram #(.WIDTH(OffW), .DEPTH(NumBins)) u_of (
        .i_clk(i_clk), .i_we(of_we), .i_waddr(of_waddr), .i_wdata(of_wdata),
        .i_raddr(of_raddr), .o_rdata(of_rdata));
    b2oc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start), .i_num(dv_num),
        .i_den(dv_den), .o_done(dv_done), .o_quot(dv_quot));

    // bin offset before truncation to 32 bits
    assign bofs = 64'(dv_quot) - 64'(r_gm);

    // next state and store control
    always_comb begin
        n_st = r_st;
        n_idx = r_idx;
        n_ov = r_ov;
        take = 1'b0;
        sc_we = 1'b0;
        sc_waddr = r_idx;
        sc_wdata = '0;
        sc_raddr = r_idx;
        of_we = 1'b0;
        of_waddr = r_idx;
        of_wdata = '0;
        of_raddr = r_cmd.bin;
        dv_start = 1'b0;
        dv_num = r_gs;
        dv_den = r_gc;
        unique case (r_st)
            ST_CLEAR: begin
                sc_we = 1'b1;
                of_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (32'(r_idx) == NumBins - 1) begin
                    n_st = ST_IDLE;
                    n_idx = '0;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid && !r_ov) begin
                    take = 1'b1;
                    sc_raddr = i_cmd.bin;
                    of_raddr = i_cmd.bin;
                    unique case (i_cmd.act)
                        ACT_ACC:  n_st = i_cmd.in_win ? ST_ACC_RD : ST_IDLE;
                        ACT_FIN:  begin n_st = ST_SUM_RD; n_idx = '0; end
                        ACT_LOOK: n_st = ST_LK_RD;
                        default:  n_st = ST_IDLE;
                    endcase
                end
            end
            ST_ACC_RD: begin
                sc_raddr = r_cmd.bin;
                n_st = ST_ACC_WR;
            end
            ST_ACC_WR: begin
                sc_waddr = r_cmd.bin;
                sc_we = (rd_cnt != {CntW{1'b1}});
                sc_wdata = {rd_sum + SumW'(r_cmd.value), rd_cnt + 1'b1};
                n_st = ST_IDLE;
            end
            ST_LK_RD: begin
                n_st = ST_LK_OUT;
            end
            ST_LK_OUT: begin
                n_ov = 1'b1;
                n_st = ST_IDLE;
            end
            ST_SUM_RD: begin
                n_st = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                n_idx = r_idx + 1'b1;
                sc_raddr = r_idx + 1'b1;
                if (32'(r_idx) == NumBins - 1) begin
                    n_st = ST_GDIV;
                    n_idx = '0;
                end else begin
                    n_st = ST_SUM_ACC;
                end
            end
            ST_GDIV: begin
                dv_start = (r_gc != '0);
                n_st = (r_gc != '0) ? ST_GWAIT : ST_BIN_RD;
            end
            ST_GWAIT: begin
                if (dv_done) n_st = ST_BIN_RD;
            end
            ST_BIN_RD: begin
                n_st = ST_BIN_CHK;
            end
            ST_BIN_CHK: begin
                dv_num = NW'(rd_sum);
                dv_den = DW'(rd_cnt);
                if (rd_cnt != '0 && rd_cnt >= i_min_count) begin
                    dv_start = 1'b1;
                    n_st = ST_BWAIT;
                end else begin
                    of_we = 1'b1;
                    n_st = ST_BDIV;
                end
            end
            ST_BWAIT: begin
                if (dv_done) begin
                    of_we = 1'b1;
                    of_wdata = bofs[OffW-1:0];
                    n_st = ST_BDIV;
                end
            end
            ST_BDIV: begin
                // advance to the next bin
                n_idx = r_idx + 1'b1;
                sc_raddr = r_idx + 1'b1;
                n_st = (32'(r_idx) == NumBins - 1) ? ST_IDLE : ST_BIN_RD;
            end
            default: n_st = ST_IDLE;
        endcase
        if (r_ov && i_pop) n_ov = 1'b0;
    end

    // state, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_CLEAR;
            r_idx   <= '0;
            r_ready <= 1'b0;
            r_ov    <= 1'b0;
            r_gm    <= '0;
        end else begin
            r_st  <= n_st;
            r_idx <= n_idx;
            r_ov  <= n_ov;
            if (r_st == ST_GWAIT && dv_done) r_gm <= dv_quot[OffW-1:0];
            if (r_st == ST_GDIV && r_gc == '0) r_gm <= '0;
            if (r_st == ST_BDIV && 32'(r_idx) == NumBins - 1) r_ready <= 1'b1;
        end
        if (take) r_cmd <= i_cmd;
        if (r_st == ST_IDLE) begin
            r_gs <= '0;
            r_gc <= '0;
        end else if (r_st == ST_SUM_ACC) begin
            r_gs <= r_gs + NW'(rd_sum);
            r_gc <= r_gc + DW'(rd_cnt);
        end
        if (r_st == ST_LK_OUT) begin
            r_ov_hit <= r_ready && r_cmd.in_win;
            r_ov_off <= (r_ready && r_cmd.in_win) ? $signed(of_rdata) : '0;
        end
    end

    assign o_cmd_take = take;
    assign o_empty    = !r_ov;
    assign o_offset   = r_ov_off;
    assign o_bin_hit  = r_ov_hit;
    assign o_busy     = (r_st != ST_IDLE) || i_cmd_valid || r_ov;

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> r_st == ST_IDLE) else $error("command taken while busy");
    a_no_take_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_pop |=> r_ov) else $error("result lost");
    a_hit_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && o_bin_hit |-> r_ready) else $error("hit before offsets ready");
endmodule

### hw/rtl/binned_2d_offset_correction_unit.sv
// binned_2d_offset_correction_unit: top level, config registers, front and back parts
// depends on b2oc_pkg, b2oc_front, b2oc_back
//
// channel  direction  handshake          payload
// input    in         i_push / o_full    i_action, i_coord_x, i_coord_y, i_sample_value
// result   out        o_empty / i_pop    o_offset, o_bin_hit
// config   in         apb psel/penable   paddr, pwdata, prdata
//
// after reset a clearing pass zeroes the bin stores; items queue meanwhile
// an item passes front stages one and two and the queue before the back can take it
// accumulate reads then writes and lookup reads then outputs (one ram read each)
// finalize: a summing walk, a global divide if any sample was counted, then a read and
// check of each bin, with a bin divide when its count is nonzero and meets the minimum
// the front holds up to four items; a waiting result stalls the back until popped
`timescale 1ns / 1ps
module binned_2d_offset_correction_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    input  logic signed [23:0] i_sample_value,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [31:0] o_offset,
    output logic               o_bin_hit,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import b2oc_pkg::*;

    logic signed [15:0] r_wlow, r_whigh;
    logic [23:0] r_minc;
    logic        cmd_valid, cmd_take, busy;
    t_cmd        cmd;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite && pready;

    // configuration register transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlow  <= -16'sd600;
            r_whigh <= 16'sd600;
            r_minc  <= 24'd20;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_WLOW:  r_wlow  <= pwdata[15:0];
                REG_WHIGH: r_whigh <= pwdata[15:0];
                REG_MINC:  r_minc  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_WLOW:  prdata = 32'(r_wlow);
            REG_WHIGH: prdata = 32'(r_whigh);
            REG_MINC:  prdata = {8'd0, r_minc};
            default:   prdata = '0;
        endcase
    end

    b2oc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_action(i_action), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_sample_value(i_sample_value), .i_wlow(r_wlow), .i_whigh(r_whigh),
        .i_cmd_take(cmd_take), .o_cmd_valid(cmd_valid), .o_cmd(cmd));

    b2oc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .i_min_count(r_minc), .o_empty(o_empty), .i_pop(i_pop),
        .o_offset(o_offset), .o_bin_hit(o_bin_hit), .o_busy(busy));

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr |-> !busy) else $error("config write while busy");
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(wr) |-> pready) else $error("pready low on access");
    a_empty_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid) else $error("take without command");
endmodule

### tb/binned_2d_offset_correction_unit_tb.sv
// binned_2d_offset_correction_unit_tb: self-checking testbench for the binned offset unit
// depends on b2oc_pkg and binned_2d_offset_correction_unit; the bin offset predictor is local
`timescale 1ns / 1ps
module binned_2d_offset_correction_unit_tb;
    import b2oc_pkg::*;

    // one expected lookup result
    typedef struct {
        logic signed [31:0] offset;
        logic               hit;
    } t_lookup_result;

    // bin offset predictor and the queue of lookup results still to come
    class bin_offset_predictor;
        longint         win_lo;
        longint         win_hi;
        longint         min_samples;
        longint         sums[NumBins];
        longint         counts[NumBins];
        int             offsets[NumBins];
        bit             ready;
        t_lookup_result pending_lookups[$];

        function void clear();
            win_lo      = -600;
            win_hi      = 600;
            min_samples = 20;
            ready       = 0;
            pending_lookups.delete();
            for (int b = 0; b < NumBins; b++) begin
                sums[b]    = 0;
                counts[b]  = 0;
                offsets[b] = 0;
            end
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_WLOW:  win_lo = longint'($signed(val[15:0]));
                REG_WHIGH: win_hi = longint'($signed(val[15:0]));
                REG_MINC:  min_samples = longint'(val[23:0]);
                default: ;
            endcase
        endfunction

        // bin index of a point, -1 outside the window
        function int bin_of(longint x, longint y);
            longint span;
            longint ix;
            longint iy;
            if (x < win_lo || x >= win_hi || y < win_lo || y >= win_hi) return -1;
            span = win_hi - win_lo;
            ix = (x - win_lo) * BinsPerAxis / span;
            iy = (y - win_lo) * BinsPerAxis / span;
            if (ix < 0 || ix >= BinsPerAxis || iy < 0 || iy >= BinsPerAxis) return -1;
            return int'(ix * BinsPerAxis + iy);
        endfunction

        // recompute every bin offset against the global mean
        function void compute_offsets();
            longint total;
            longint samples;
            longint mean;
            total   = 0;
            samples = 0;
            mean    = 0;
            for (int b = 0; b < NumBins; b++) begin
                total   += sums[b];
                samples += counts[b];
            end
            if (samples > 0) mean = total / samples;
            for (int b = 0; b < NumBins; b++) begin
                if (counts[b] > 0 && counts[b] >= min_samples)
                    offsets[b] = int'(sums[b] / counts[b] - mean);
                else
                    offsets[b] = 0;
            end
            ready = 1;
        endfunction

        // note an accepted input transfer
        function void note_item(t_action act, logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [23:0] v);
            int             b;
            t_lookup_result r;
            b = bin_of(x, y);
            case (act)
                ACT_ACC: begin
                    if (b >= 0 && counts[b] < 64'hFFFFFF) begin
                        sums[b]   += longint'(v);
                        counts[b] += 1;
                    end
                end
                ACT_FIN: compute_offsets();
                ACT_LOOK: begin
                    if (!ready || b < 0) begin
                        r.offset = 0;
                        r.hit    = 0;
                    end else begin
                        r.offset = offsets[b];
                        r.hit    = 1;
                    end
                    pending_lookups = {pending_lookups, r};
                end
                default: ;
            endcase
        endfunction

        // compare a result transfer with the oldest expectation; returns 1 on mismatch
        function bit check_lookup(logic signed [31:0] offset, logic hit, output string msg);
            t_lookup_result r;
            if (pending_lookups.size() == 0) begin
                msg = $sformatf("unexpected result offset=%0d hit=%0b", offset, hit);
                return 1;
            end
            r = pending_lookups.pop_front();
            if (offset !== r.offset || hit !== r.hit) begin
                msg = $sformatf("result offset=%0d hit=%0b, want offset=%0d hit=%0b",
                                offset, hit, r.offset, r.hit);
                return 1;
            end
            return 0;
        endfunction
    endclass

    localparam int WatchdogLimit = 200000;
    localparam int SettleCycles  = 4;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_push = 0;
    logic               o_full;
    logic [1:0]         i_action = ACT_NONE;
    logic signed [15:0] i_coord_x = 0;
    logic signed [15:0] i_coord_y = 0;
    logic signed [23:0] i_sample_value = 0;
    logic               o_empty;
    logic               i_pop = 0;
    logic signed [31:0] o_offset;
    logic               o_bin_hit;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [3:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    bin_offset_predictor predictor;
    int                  mismatch_count = 0;
    int                  idle_cycles = 0;
    bit                  sender_bursty = 1;
    bit                  receiver_bursty = 1;

    binned_2d_offset_correction_unit uut (.*);

    always #5 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random pop gaps, check each transfer
    initial begin
        int    gap;
        string msg;
        predictor = new();
        predictor.clear();
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 99) < 3) receiver_bursty = ~receiver_bursty;
            gap = receiver_bursty ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                i_pop <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_pop <= 1;
            @(posedge i_clk);
            while (o_empty) @(posedge i_clk);
            if (predictor.check_lookup(o_offset, o_bin_hit, msg)) report(msg);
        end
    end

    // one apb register write
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= 4'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        predictor.set_reg(idx, val);
    endtask

    // one input transfer after a random gap
    task automatic send(t_action act, int x, int y, int v);
        int gap;
        if ($urandom_range(0, 99) < 3) sender_bursty = ~sender_bursty;
        gap = sender_bursty ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_push         <= 1;
        i_action       <= act;
        i_coord_x      <= 16'(x);
        i_coord_y      <= 16'(y);
        i_sample_value <= 24'(v);
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predictor.note_item(act, 16'(x), 16'(y), 24'(v));
    endtask

    // a trailing lookup marks the end of the work; once it returns, set new registers
    task automatic configure(int lo, int hi, int minc);
        send(ACT_LOOK, 0, 0, 0);
        i_push <= 0;
        while (predictor.pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        write_reg(REG_WLOW, 32'(lo));
        write_reg(REG_WHIGH, 32'(hi));
        write_reg(REG_MINC, 32'(minc));
    endtask

    // random point: mostly inside the window, sometimes anywhere
    function automatic int pick_coord();
        int lo;
        int hi;
        lo = int'(predictor.win_lo);
        hi = int'(predictor.win_hi);
        if (hi > lo && $urandom_range(0, 99) < 85)
            return lo + int'($urandom_range(0, hi - lo - 1));
        return int'($signed(16'($urandom)));
    endfunction

    task automatic send_random(int n);
        int        roll;
        t_action   act;
        int        v;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) act = ACT_ACC;
            else if (roll < 95) act = ACT_LOOK;
            else if (roll < 97) act = ACT_FIN;
            else act = ACT_NONE;
            if ($urandom_range(0, 9) == 0) v = int'($signed(24'($urandom)));
            else v = int'($urandom_range(0, 4000)) - 1000;
            send(act, pick_coord(), pick_coord(), v);
        end
    endtask

    // stimulus
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: lookup before finalize, finalize with no samples, window edges
        send(ACT_LOOK, 0, 0, 0);
        send(ACT_FIN, 0, 0, 0);
        send(ACT_LOOK, 0, 0, 0);
        send(ACT_ACC, -600, -600, 8388607);
        send(ACT_ACC, 599, 599, -8388608);
        send(ACT_ACC, 600, 0, 5);
        send(ACT_ACC, -601, 0, 5);
        send(ACT_ACC, -32768, 32767, 1);
        send(ACT_NONE, 0, 0, 7);
        send(ACT_FIN, 0, 0, 0);
        send(ACT_LOOK, -600, -600, 0);
        send(ACT_LOOK, 599, 599, 0);
        send(ACT_LOOK, 600, 0, 0);
        send(ACT_LOOK, 32767, -32768, 0);
        send(ACT_FIN, 0, 0, 0);
        send(ACT_LOOK, -600, -600, 0);

        // random phases over several window and threshold settings
        configure(-600, 600, 1);
        send_random(250);
        configure(-32768, 32767, 0);
        send(ACT_FIN, 0, 0, 0);
        send(ACT_LOOK, 32767, 32767, 0);
        send(ACT_LOOK, -32768, -32768, 0);
        send_random(250);
        configure(100, 100, 3);
        send_random(60);
        configure(-50, 70, 16777215);
        send_random(150);
        configure(-1000, 200, 5);
        send_random(300);
        configure(0, 12, 2);
        send_random(200);
        configure(-600, 600, 20);
        send_random(150);
        send(ACT_FIN, 0, 0, 0);
        send(ACT_LOOK, 0, 0, 0);
        i_push <= 0;

        // drain
        while (predictor.pending_lookups.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/b2oc_pkg.sv
hw/rtl/b2oc_ram.sv
hw/rtl/b2oc_divider.sv
hw/rtl/b2oc_front.sv
hw/rtl/b2oc_back.sv
hw/rtl/binned_2d_offset_correction_unit.sv
tb/binned_2d_offset_correction_unit_tb.sv
